@@ hdl/rsd_pkg.sv @@
// Shared types, widths and constants of the rudder servo drive.
`default_nettype none
package rsd_pkg;

  localparam int ADC_BITS   = 10;
  localparam int ERR_W      = 16;
  localparam int ANGLE_W    = 9;
  localparam int TARGET_W   = 8;
  localparam int PCT_W      = 8;
  localparam int PWM_W      = 18;
  localparam int DIFF_W     = 10;
  localparam int MAG_W      = 7;

  // delta * 100 and the divisor shifted by up to eight places
  localparam int NUM_W      = ADC_BITS + 7;
  localparam int CMP_W      = ADC_BITS + 9;
  localparam int Q_W        = 9;

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;

  localparam int CFG_IDX_W  = 2;

  localparam int PCT_SCALE  = 100;
  localparam int ANGLE_SAT  = 200;
  localparam int DRIVE_MIN  = 20;
  localparam int DRIVE_MAX  = 100;
  localparam int PWM_SCALE  = 1440;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PORT    = 2'd0,
    CFG_NEUTRAL = 2'd1,
    CFG_STBD    = 2'd2
  } cfg_index_t;

  typedef struct packed {
    logic [ADC_BITS-1:0] port_limit_pos;
    logic [ADC_BITS-1:0] neutral_pos;
    logic [ADC_BITS-1:0] stbd_limit_pos;
  } rsd_cfg_t;

  // One classified sample as it travels from front to back
  typedef struct packed {
    logic [ADC_BITS-1:0]        delta;
    logic [ADC_BITS-1:0]        span;
    logic                       neg;
    logic                       mid;
    logic                       empty;
    logic signed [TARGET_W-1:0] target;
  } rsd_item_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic push;
    logic full;
  } rsd_wr_t;

  typedef struct packed {
    logic pop;
    logic empty;
  } rsd_rd_t;

  // Quantize an error magnitude into a target step
  function automatic logic [TARGET_W-1:0] target_step(input logic [ERR_W:0] a);
    logic [TARGET_W-1:0] t;
    if (a == '0) begin
      t = TARGET_W'(0);
    end else if (a <= (ERR_W+1)'(5)) begin
      t = TARGET_W'(5);
    end else if (a <= (ERR_W+1)'(10)) begin
      t = TARGET_W'(10);
    end else if (a <= (ERR_W+1)'(30)) begin
      t = TARGET_W'(25);
    end else if (a <= (ERR_W+1)'(50)) begin
      t = TARGET_W'(50);
    end else if (a <= (ERR_W+1)'(75)) begin
      t = TARGET_W'(75);
    end else begin
      t = TARGET_W'(100);
    end
    return t;
  endfunction

endpackage
`default_nettype wire

@@ hdl/rsd_front.sv @@
// Front end: accept input beats and classify the sample side and target step.
`default_nettype none
module rsd_front
  import rsd_pkg::*;
(
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [ADC_BITS-1:0]      rudder_sample,
  input  logic signed [ERR_W-1:0]  track_error,
  input  rsd_cfg_t                 cfg,
  input  logic                     fifo_full,
  output rsd_wr_t                  wr,
  output rsd_item_t                item
);

  logic [ADC_BITS:0] lo_span;
  logic [ADC_BITS:0] hi_span;
  logic [ERR_W:0]    err_ext;
  logic [ERR_W:0]    err_abs;
  logic [TARGET_W-1:0] step;

  assign s_tready = !fifo_full;
  assign wr.push  = s_tvalid && !fifo_full;
  assign wr.full  = fifo_full;

  always_comb begin
    lo_span = {1'b0, cfg.neutral_pos} - {1'b0, cfg.port_limit_pos};
    hi_span = {1'b0, cfg.stbd_limit_pos} - {1'b0, cfg.neutral_pos};
    err_ext = {track_error[ERR_W-1], track_error};
    err_abs = track_error[ERR_W-1] ? (~err_ext + 1'b1) : err_ext;
    step    = target_step(err_abs);

    item.target = track_error[ERR_W-1] ? signed'(~step + 1'b1) : signed'(step);
    item.mid    = (rudder_sample == cfg.neutral_pos);
    item.neg    = (rudder_sample < cfg.neutral_pos);
    if (rudder_sample < cfg.neutral_pos) begin
      item.delta = cfg.neutral_pos - rudder_sample;
      item.span  = lo_span[ADC_BITS-1:0];
      item.empty = lo_span[ADC_BITS] || (lo_span == '0);
    end else begin
      item.delta = rudder_sample - cfg.neutral_pos;
      item.span  = hi_span[ADC_BITS-1:0];
      item.empty = hi_span[ADC_BITS] || (hi_span == '0);
    end
  end

endmodule
`default_nettype wire

@@ hdl/rsd_fifo.sv @@
// Short queue of classified items between front and back.
`default_nettype none
module rsd_fifo
  import rsd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  rsd_wr_t   wr,
  input  rsd_item_t wr_item,
  input  logic      pop,
  output rsd_rd_t   rd,
  output rsd_item_t rd_item,
  output logic      full
);

  rsd_item_t          mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wptr;
  logic [FIFO_AW-1:0] rptr;
  logic [FIFO_AW:0]   count;
  logic               do_pop;

  assign full     = (count == (FIFO_AW+1)'(FIFO_DEPTH));
  assign rd.empty = (count == '0);
  assign rd.pop   = do_pop;
  assign do_pop   = pop && (count != '0);
  assign rd_item  = mem[rptr];

  always_ff @(posedge clk) begin
    if (wr.push) begin
      mem[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (wr.push) begin
        wptr <= wptr + 1'b1;
      end
      if (do_pop) begin
        rptr <= rptr + 1'b1;
      end
      case ({wr.push, do_pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

@@ hdl/rsd_back.sv @@
// Back end: pipelined angle divider, drive shaping and output register.
`default_nettype none
module rsd_back
  import rsd_pkg::*;
(
  input  logic                       clk,
  input  logic                       rst,
  input  rsd_item_t                  item,
  input  rsd_rd_t                    rd,
  output logic                       pop,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  output logic signed [ANGLE_W-1:0]  rudder_angle,
  output logic signed [TARGET_W-1:0] steer_target,
  output logic                       drive_on,
  output logic                       drive_port,
  output logic signed [PCT_W-1:0]    drive_percent,
  output logic [PWM_W-1:0]           pwm_compare
);

  typedef struct packed {
    logic [CMP_W-1:0]           rem;
    logic [ADC_BITS-1:0]        span;
    logic [Q_W-1:0]             q;
    logic                       neg;
    logic                       mid;
    logic                       empty;
    logic signed [TARGET_W-1:0] target;
  } div_t;

  div_t st      [Q_W+1];
  div_t div_nxt [Q_W];
  logic vld     [Q_W+1];

  logic                       advance;
  logic                       ag_vld;
  logic signed [ANGLE_W-1:0]  ag_angle;
  logic signed [TARGET_W-1:0] ag_target;

  logic [7:0]                 a_mag;
  logic signed [ANGLE_W-1:0]  a_pos;
  logic signed [ANGLE_W-1:0]  angle_next;

  logic signed [DIFF_W-1:0]   d;
  logic [DIFF_W-1:0]          d_abs;
  logic [MAG_W-1:0]           mag;
  logic signed [PCT_W-1:0]    pct_next;
  logic [PWM_W-1:0]           pwm_next;

  // The whole back pipeline moves together; hold it while the result waits
  assign advance = !m_tvalid || m_tready;
  assign pop     = advance && !rd.empty;

  // One quotient bit per stage, highest first; the top bit flags overflow
  for (genvar s = 0; s < Q_W; s++) begin : g_step
    localparam int K = Q_W - 1 - s;
    logic [CMP_W-1:0] dv;
    logic             ge;
    assign dv = CMP_W'(st[s].span) << K;
    assign ge = (st[s].rem >= dv);
    always_comb begin
      div_nxt[s]      = st[s];
      div_nxt[s].rem  = ge ? (st[s].rem - dv) : st[s].rem;
      div_nxt[s].q[K] = ge;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s <= Q_W; s++) begin
        vld[s] <= 1'b0;
      end
      ag_vld   <= 1'b0;
      m_tvalid <= 1'b0;
    end else if (advance) begin
      vld[0] <= !rd.empty;
      for (int s = 0; s < Q_W; s++) begin
        vld[s+1] <= vld[s];
      end
      ag_vld   <= vld[Q_W];
      m_tvalid <= ag_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      st[0].rem    <= CMP_W'(NUM_W'(item.delta) * NUM_W'(PCT_SCALE));
      st[0].span   <= item.span;
      st[0].q      <= '0;
      st[0].neg    <= item.neg;
      st[0].mid    <= item.mid;
      st[0].empty  <= item.empty;
      st[0].target <= item.target;
      for (int s = 0; s < Q_W; s++) begin
        st[s+1] <= div_nxt[s];
      end
      ag_angle      <= angle_next;
      ag_target     <= st[Q_W].target;
      rudder_angle  <= ag_angle;
      steer_target  <= ag_target;
      drive_on      <= (d != '0);
      drive_port    <= d[DIFF_W-1];
      drive_percent <= pct_next;
      pwm_compare   <= pwm_next;
    end
  end

  // Saturate the quotient and apply the side
  always_comb begin
    if (st[Q_W].empty || st[Q_W].q[Q_W-1] || (st[Q_W].q[7:0] > 8'(ANGLE_SAT))) begin
      a_mag = 8'(ANGLE_SAT);
    end else begin
      a_mag = st[Q_W].q[7:0];
    end
    a_pos = signed'(ANGLE_W'(a_mag));
    if (st[Q_W].mid) begin
      angle_next = '0;
    end else if (st[Q_W].neg) begin
      angle_next = -a_pos;
    end else begin
      angle_next = a_pos;
    end
  end

  // Drive error, minimum and maximum drive, PWM scaling
  always_comb begin
    d     = DIFF_W'(ag_target) - DIFF_W'(ag_angle);
    d_abs = d[DIFF_W-1] ? DIFF_W'(-d) : DIFF_W'(d);
    if (d == '0) begin
      mag = '0;
    end else if (d_abs < DIFF_W'(DRIVE_MIN)) begin
      mag = MAG_W'(DRIVE_MIN);
    end else if (d_abs > DIFF_W'(DRIVE_MAX)) begin
      mag = MAG_W'(DRIVE_MAX);
    end else begin
      mag = d_abs[MAG_W-1:0];
    end
    pct_next = d[DIFF_W-1] ? -signed'(PCT_W'(mag)) : signed'(PCT_W'(mag));
    pwm_next = PWM_W'(mag) * PWM_W'(PWM_SCALE);
  end

endmodule
`default_nettype wire

@@ hdl/rudder_servo_drive.sv @@
// Top level of the rudder servo drive: configuration, front, queue and back.
//
//  channel  | direction | beat contents
//  ---------+-----------+-------------------------------------------------
//  s_axis   | in        | rudder sample and cross-track error
//  m_axis   | out       | angle, target, drive flags, drive percent, PWM
//  cfg      | in        | write of port, neutral or starboard ADC limit
//
// One beat per cycle sustained while m_tready stays high; a result passes
// through the queue, the operand register behind it, nine divider stages
// (one quotient bit each), the angle stage and the output register.
// Reset restores the default limits; nothing is swept.
// A low m_tready with a result waiting freezes the back pipeline; the
// four-entry queue absorbs beats until it fills, then s_tready drops.
`default_nettype none
module rudder_servo_drive
  import rsd_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  // [9:0] rudder_sample, [25:10] track_error, [31:26] zero
  input  logic [31:0]          s_tdata,
  output logic                 m_tvalid,
  input  logic                 m_tready,
  // [8:0] rudder_angle, [16:9] steer_target, [17] drive_on, [18] drive_port,
  // [26:19] drive_percent, [44:27] pwm_compare, [47:45] zero
  output logic [47:0]          m_tdata,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADC_BITS-1:0]  cfg_data
);

  rsd_cfg_t  cfg;
  rsd_wr_t   wr;
  rsd_rd_t   rd;
  rsd_item_t wr_item;
  rsd_item_t rd_item;
  logic      fifo_full;
  logic      pop;

  logic signed [ANGLE_W-1:0]  rudder_angle;
  logic signed [TARGET_W-1:0] steer_target;
  logic                       drive_on;
  logic                       drive_port;
  logic signed [PCT_W-1:0]    drive_percent;
  logic [PWM_W-1:0]           pwm_compare;

  // Limit registers; writes to an unused index are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.port_limit_pos <= ADC_BITS'(0);
      cfg.neutral_pos    <= ADC_BITS'(512);
      cfg.stbd_limit_pos <= ADC_BITS'(1023);
    end else if (cfg_we) begin
      case (cfg_index_t'(cfg_index))
        CFG_PORT:    cfg.port_limit_pos <= cfg_data;
        CFG_NEUTRAL: cfg.neutral_pos    <= cfg_data;
        CFG_STBD:    cfg.stbd_limit_pos <= cfg_data;
        default:     cfg <= cfg;
      endcase
    end
  end

  rsd_front u_front (
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .rudder_sample (s_tdata[ADC_BITS-1:0]),
    .track_error   (signed'(s_tdata[ADC_BITS+ERR_W-1:ADC_BITS])),
    .cfg           (cfg),
    .fifo_full     (fifo_full),
    .wr            (wr),
    .item          (wr_item)
  );

  rsd_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .wr_item (wr_item),
    .pop     (pop),
    .rd      (rd),
    .rd_item (rd_item),
    .full    (fifo_full)
  );

  rsd_back u_back (
    .clk           (clk),
    .rst           (rst),
    .item          (rd_item),
    .rd            (rd),
    .pop           (pop),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .rudder_angle  (rudder_angle),
    .steer_target  (steer_target),
    .drive_on      (drive_on),
    .drive_port    (drive_port),
    .drive_percent (drive_percent),
    .pwm_compare   (pwm_compare)
  );

  // Pack the result fields, lowest field first
  assign m_tdata = {3'b000, pwm_compare, drive_percent, drive_port, drive_on,
                    steer_target, rudder_angle};

endmodule
`default_nettype wire

@@ tb/sv/rudder_servo_drive_tb.sv @@
// Testbench for the rudder servo drive: directed and random beats against a drive predictor.
`timescale 1ns / 100ps
module rudder_servo_drive_tb;
  import rsd_pkg::*;

  // Index 3 decodes to no register; writes there must leave the limits alone
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;
  localparam int ADC_TOP       = (1 << ADC_BITS) - 1;
  localparam int IDLE_MAX      = 12;
  localparam int SETTLE_CYCLES = 20;   // pipeline is about 13 deep
  localparam int DRAIN_LIMIT   = 4000;
  localparam int PRINT_CAP     = 100;

  typedef struct {
    logic signed [ANGLE_W-1:0]  rudder_angle;
    logic signed [TARGET_W-1:0] steer_target;
    logic                       drive_on;
    logic                       drive_port;
    logic signed [PCT_W-1:0]    drive_percent;
    logic [PWM_W-1:0]           pwm_compare;
  } drive_cmd_t;

  logic                 clk = 1'b0;
  logic                 rst;
  logic                 s_tvalid;
  logic                 s_tready;
  // [9:0] rudder_sample, [25:10] track_error, [31:26] zero
  logic [31:0]          s_tdata;
  logic                 m_tvalid;
  logic                 m_tready;
  // [8:0] rudder_angle, [16:9] steer_target, [17] drive_on, [18] drive_port,
  // [26:19] drive_percent, [44:27] pwm_compare, [47:45] zero
  logic [47:0]          m_tdata;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [ADC_BITS-1:0]  cfg_data;

  // Shadow copy of the limit registers, as last written
  int port_lim;
  int neutral;
  int stbd_lim;

  drive_cmd_t pending_cmds[$];

  int errors;
  int samples_sent;
  int results_seen;
  int stopped_seen;
  int port_seen;
  int cfg_writes;
  int send_idle_max;
  int recv_idle_max;

  rudder_servo_drive dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------

  // Scale a distance from neutral onto percent of one side's span
  function automatic int side_scale(int offset, int span);
    int q;
    if (span <= 0) return ANGLE_SAT;   // empty span pins the angle
    q = offset * PCT_SCALE / span;
    return (q > ANGLE_SAT) ? ANGLE_SAT : q;
  endfunction

  function automatic drive_cmd_t predict_cmd(logic [ADC_BITS-1:0] raw,
                                             logic signed [ERR_W-1:0] err);
    drive_cmd_t c;
    int r;
    int angle;
    int err_mag;
    int step;
    int diff;
    int mag;
    r = int'(raw);
    if (r < neutral) begin
      angle = -side_scale(neutral - r, neutral - port_lim);
    end else if (r > neutral) begin
      angle = side_scale(r - neutral, stbd_lim - neutral);
    end else begin
      angle = 0;
    end

    // Quantize the error magnitude into the target ladder
    err_mag = (err < 0) ? -int'(err) : int'(err);
    if (err_mag == 0) step = 0;
    else if (err_mag <= 5) step = 5;
    else if (err_mag <= 10) step = 10;
    else if (err_mag <= 30) step = 25;
    else if (err_mag <= 50) step = 50;
    else if (err_mag <= 75) step = 75;
    else step = 100;
    if (err < 0) step = -step;

    // A zero difference between target and angle stops the motor; otherwise hold the drive within its band
    diff = step - angle;
    mag = (diff < 0) ? -diff : diff;
    if (diff != 0) begin
      if (mag < DRIVE_MIN) mag = DRIVE_MIN;
      if (mag > DRIVE_MAX) mag = DRIVE_MAX;
    end
    c.rudder_angle  = ANGLE_W'(angle);
    c.steer_target  = TARGET_W'(step);
    c.drive_on      = (diff != 0);
    c.drive_port    = (diff < 0);
    c.drive_percent = PCT_W'((diff < 0) ? -mag : mag);
    c.pwm_compare   = PWM_W'(mag * PWM_SCALE);
    return c;
  endfunction

  function automatic drive_cmd_t unpack_cmd(logic [47:0] d);
    drive_cmd_t c;
    c.rudder_angle  = d[8:0];
    c.steer_target  = d[16:9];
    c.drive_on      = d[17];
    c.drive_port    = d[18];
    c.drive_percent = d[26:19];
    c.pwm_compare   = d[44:27];
    return c;
  endfunction

  // ---------------------------------------------------------------------
  // Reporting and result checking
  // ---------------------------------------------------------------------

  task automatic report_mismatch(string what, longint got, longint want);
    errors++;
    if (errors <= PRINT_CAP)
      $display("ERROR at %0t: %s: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic check_field(string what, longint got, longint want);
    if (got != want) report_mismatch(what, got, want);
  endtask

  // Compare each accepted result beat with the oldest prediction
  always @(posedge clk) begin
    drive_cmd_t got;
    drive_cmd_t want;
    if (!rst && m_tvalid && m_tready) begin
      got = unpack_cmd(m_tdata);
      results_seen++;
      if (got.drive_on == 1'b0) stopped_seen++;
      if (got.drive_port) port_seen++;
      if (pending_cmds.size() == 0) begin
        report_mismatch("result beat with nothing pending", m_tdata, 0);
      end else begin
        want = pending_cmds.pop_front();
        check_field("rudder_angle", int'(got.rudder_angle), int'(want.rudder_angle));
        check_field("steer_target", int'(got.steer_target), int'(want.steer_target));
        check_field("drive_on", got.drive_on, want.drive_on);
        check_field("drive_port", got.drive_port, want.drive_port);
        check_field("drive_percent", int'(got.drive_percent), int'(want.drive_percent));
        check_field("pwm_compare", got.pwm_compare, want.pwm_compare);
      end
    end
  end

  // ---------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------

  // At least a quarter of draws are zero so short bursts show up even under idling
  function automatic int draw_idle(int top);
    if (top == 0) return 0;
    return ($urandom_range(0, 3) == 0) ? 0 : int'($urandom_range(0, top));
  endfunction

  // Receiver: stall a random number of cycles before taking each beat
  initial begin
    int stall;
    m_tready = 1'b0;
    wait (rst === 1'b0);
    @(negedge clk);
    forever begin
      stall = draw_idle(recv_idle_max);
      if (stall > 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      m_tready <= 1'b1;
      do @(posedge clk); while (!m_tvalid);
      @(negedge clk);
    end
  end

  // Send one sample beat; enter and leave on a falling edge
  task automatic send_sample(logic [ADC_BITS-1:0] raw, logic signed [ERR_W-1:0] err);
    int gap;
    gap = draw_idle(send_idle_max);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {6'b0, err, raw};
    do @(posedge clk); while (!s_tready);
    pending_cmds.push_back(predict_cmd(raw, err));
    samples_sent++;
    @(negedge clk);
  endtask

  // Drop valid and hold until every predicted beat is back, then let the
  // pipeline settle
  task automatic wait_all_results();
    int waited;
    waited = 0;
    s_tvalid <= 1'b0;
    while (pending_cmds.size() != 0 && waited < DRAIN_LIMIT) begin
      @(negedge clk);
      waited++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  // Leaves cfg_we high; the caller drops it once its writes are done
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, int value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= ADC_BITS'(value);
    @(negedge clk);
    case (idx)
      CFG_PORT:    port_lim = value & ADC_TOP;
      CFG_NEUTRAL: neutral  = value & ADC_TOP;
      CFG_STBD:    stbd_lim = value & ADC_TOP;
      default: ;
    endcase
    cfg_writes++;
  endtask

  task automatic set_limits(int p, int n, int s);
    wait_all_results();
    write_reg(CFG_PORT, p);
    write_reg(CFG_NEUTRAL, n);
    write_reg(CFG_STBD, s);
    cfg_we <= 1'b0;
  endtask

  // Mostly ordered limits, some with narrow spans so the angle saturates;
  // now and then any order at all
  task automatic random_limits();
    int n;
    int reach;
    int p;
    int s;
    if ($urandom_range(0, 4) == 0) begin
      set_limits($urandom_range(0, ADC_TOP), $urandom_range(0, ADC_TOP),
                 $urandom_range(0, ADC_TOP));
    end else begin
      n = $urandom_range(1, ADC_TOP - 1);
      reach = ($urandom_range(0, 1) != 0) ? n : ((n < 16) ? n : 16);
      p = n - int'($urandom_range(1, reach));
      reach = ADC_TOP - n;
      if ($urandom_range(0, 1) == 0 && reach > 16) reach = 16;
      s = n + int'($urandom_range(1, reach));
      set_limits(p, n, s);
    end
  endtask

  function automatic logic [ADC_BITS-1:0] pick_sample();
    int r;
    case ($urandom_range(0, 7))
      0: r = port_lim;
      1: r = neutral;
      2: r = stbd_lim;
      3, 4: r = neutral + int'($urandom_range(0, 8)) - 4;
      default: r = $urandom_range(0, ADC_TOP);
    endcase
    if (r < 0) r = 0;
    if (r > ADC_TOP) r = ADC_TOP;
    return ADC_BITS'(r);
  endfunction

  // Most errors sit near the ladder; some span the whole 16-bit range
  function automatic logic signed [ERR_W-1:0] pick_error();
    int r;
    case ($urandom_range(0, 9))
      0: r = 0;
      1, 2, 3: r = int'($urandom_range(0, 65535)) - 32768;
      default: r = int'($urandom_range(0, 200)) - 100;
    endcase
    return ERR_W'(r);
  endfunction

  // ---------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------

  // Walk the target ladder across each boundary with the rudder amidships
  task automatic test_error_steps();
    int steps[18] = '{0, 1, 5, 6, 10, 11, 30, 31, 50, 51, 75, 76, 32767,
                      -1, -5, -6, -76, -32768};
    foreach (steps[i]) send_sample(ADC_BITS'(512), ERR_W'(steps[i]));
  endtask

  // Full-scale samples, both sides of neutral, and the drive clamps
  task automatic test_angle_extremes();
    send_sample('0, '0);
    send_sample(ADC_BITS'(ADC_TOP), '0);
    send_sample(ADC_BITS'(511), ERR_W'(-5));
    send_sample(ADC_BITS'(513), ERR_W'(5));
    send_sample('0, ERR_W'(32767));
  endtask

  // Collapse both spans, then try the unused register index
  task automatic test_empty_spans();
    set_limits(600, 600, 600);
    send_sample('0, ERR_W'(-32768));
    send_sample(ADC_BITS'(ADC_TOP), ERR_W'(32767));
    send_sample(ADC_BITS'(600), '0);
    wait_all_results();
    write_reg(CFG_SPARE, ADC_TOP);
    cfg_we <= 1'b0;
    send_sample(ADC_BITS'(599), ERR_W'(20));
    send_sample(ADC_BITS'(601), ERR_W'(-20));
  endtask

  // Fixed corner settings, each with a burst of random beats
  task automatic test_limit_corners();
    int corners[6][3] = '{'{0, 0, ADC_TOP}, '{0, ADC_TOP, ADC_TOP}, '{0, 1, 2},
                          '{ADC_TOP - 2, ADC_TOP - 1, ADC_TOP}, '{ADC_TOP, 0, 0},
                          '{0, 512, ADC_TOP}};
    foreach (corners[k]) begin
      set_limits(corners[k][0], corners[k][1], corners[k][2]);
      repeat (30) send_sample(pick_sample(), pick_error());
    end
  endtask

  // Random limits per phase; vary idling on both sides, with some phases
  // free of gaps entirely
  task automatic test_random_traffic();
    for (int phase = 0; phase < 12; phase++) begin
      random_limits();
      send_idle_max = (phase % 4 == 0 || phase % 4 == 2) ? 0 : IDLE_MAX;
      recv_idle_max = (phase % 4 == 0 || phase % 4 == 1) ? 0 : IDLE_MAX;
      for (int n = 0; n < 140; n++) begin
        // hold off mid-phase until everything in flight has come back
        if (phase == 5 && n == 70) wait_all_results();
        send_sample(pick_sample(), pick_error());
      end
    end
  endtask

  initial begin
    rst           = 1'b1;
    s_tvalid      = 1'b0;
    s_tdata       = '0;
    cfg_we        = 1'b0;
    cfg_index     = CFG_PORT;
    cfg_data      = '0;
    port_lim      = 0;
    neutral       = 512;
    stbd_lim      = ADC_TOP;
    errors        = 0;
    samples_sent  = 0;
    results_seen  = 0;
    stopped_seen  = 0;
    port_seen     = 0;
    cfg_writes    = 0;
    send_idle_max = 4;
    recv_idle_max = 4;
    repeat (8) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    test_error_steps();
    test_angle_extremes();
    test_empty_spans();
    send_idle_max = IDLE_MAX;
    recv_idle_max = IDLE_MAX;
    test_limit_corners();
    test_random_traffic();

    wait_all_results();
    if (pending_cmds.size() != 0)
      report_mismatch("result beats never arrived", pending_cmds.size(), 0);
    $display("Sent %0d sample beats across %0d register writes; checked %0d results.",
             samples_sent, cfg_writes, results_seen);
    $display("Drive stopped on %0d results and ran toward port on %0d.",
             stopped_seen, port_seen);
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run
  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

endmodule
